### sv/jsu8_pkg.sv
package jsu8_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_status;

    // Result status codes
    localparam t_status ST_DATA = 2'd0;
    localparam t_status ST_END  = 2'd1;
    localparam t_status ST_ERR  = 2'd2;

    // Parser modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_STR    = 3'd1;
    localparam logic [2:0] M_ESC    = 3'd2;
    localparam logic [2:0] M_HEX1   = 3'd3;
    localparam logic [2:0] M_SUR_BS = 3'd4;
    localparam logic [2:0] M_SUR_U  = 3'd5;
    localparam logic [2:0] M_HEX2   = 3'd6;

    // Source characters
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CH_B      = 8'h62;
    localparam t_byte CH_F      = 8'h66;
    localparam t_byte CH_N      = 8'h6E;
    localparam t_byte CH_R      = 8'h72;
    localparam t_byte CH_T      = 8'h74;
    localparam t_byte CH_U      = 8'h75;
    localparam t_byte CH_SPACE  = 8'h20;

    // Surrogate ranges and code point limits
    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] CP_SUPP    = 21'h10000;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input t_byte c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

### sv/json_string_unescape_utf8_unit.sv
// JSON string unescaper: takes source text one byte per cycle, waits for an
// opening quote, then delivers the string's content as UTF-8 bytes, with
// \" \\ \/ \b \f \n \r \t and \uXXXX escapes (surrogate pairs combined)
// decoded. A closing quote gives one end result, and any malformed input
// gives one error result and drops back to waiting for a quote. o_last marks
// the final result caused by one input byte. Each byte passes an input
// register and one step of decode logic into a four-entry result buffer,
// so the block takes one byte per cycle as long as every byte yields at
// most one result and the output is not stalled; a \u escape that decodes
// to a code point above 0x7F yields two to four bytes, and the single output
// port then delivers them one at a time, holding further input meanwhile.
module json_string_unescape_utf8_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_in_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output jsu8_pkg::t_status    o_status,
    output logic                 o_last
);
    import jsu8_pkg::*;

    // Input register
    logic        r_in_vld;
    t_byte       r_in_byte;

    // Parser state
    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [9:0]  r_hsur, n_hsur;

    // Result buffer
    logic        r_ovld;
    t_byte       r_buf [4];
    t_status     r_bst;
    logic [1:0]  r_pos;
    logic [1:0]  r_num;

    // Decode outputs
    logic [2:0]  d_num;
    t_status     d_st;
    t_byte       d_b [4];
    logic        d_fail;
    logic        d_emit;
    logic [20:0] d_cp;
    logic [4:0]  hd;
    logic [15:0] v16;

    logic        take;
    logic        res_free;
    logic        proc;
    logic        accept;

    // Handshake
    assign take     = r_ovld && !i_out_stall;
    assign res_free = !r_ovld || (take && (r_pos == r_num));
    assign proc     = r_in_vld && res_free;
    assign o_in_stall = r_in_vld && !res_free;
    assign accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_ovld;
    assign o_out_byte  = r_buf[r_pos];
    assign o_status    = r_bst;
    assign o_last      = (r_pos == r_num);

    // Decode of one byte against the parser state
    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_hcnt = r_hcnt;
        n_hsur = r_hsur;
        d_num  = 3'd0;
        d_st   = ST_DATA;
        for (int k = 0; k < 4; k++) begin
            d_b[k] = 8'd0;
        end
        d_fail = 1'b0;
        d_emit = 1'b0;
        d_cp   = 21'd0;
        hd     = hex_digit(r_in_byte);
        v16    = {r_hex[11:0], hd[3:0]};

        case (r_mode)
            M_IDLE: begin
                if (r_in_byte == CH_QUOTE) begin
                    n_mode = M_STR;
                end else if (r_in_byte != 8'd0) begin
                    d_fail = 1'b1;
                end
            end
            M_STR: begin
                if (r_in_byte == CH_QUOTE) begin
                    n_mode = M_IDLE;
                    d_num  = 3'd1;
                    d_st   = ST_END;
                end else if (r_in_byte == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else if (r_in_byte < CH_SPACE) begin
                    d_fail = 1'b1;
                end else begin
                    d_num  = 3'd1;
                    d_b[0] = r_in_byte;
                end
            end
            M_ESC: begin
                n_mode = M_STR;
                d_num  = 3'd1;
                case (r_in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: d_b[0] = r_in_byte;
                    CH_B: d_b[0] = 8'h08;
                    CH_F: d_b[0] = 8'h0C;
                    CH_N: d_b[0] = 8'h0A;
                    CH_R: d_b[0] = 8'h0D;
                    CH_T: d_b[0] = 8'h09;
                    CH_U: begin
                        n_mode = M_HEX1;
                        n_hex  = 16'd0;
                        n_hcnt = 2'd0;
                        d_num  = 3'd0;
                    end
                    default: d_fail = 1'b1;
                endcase
            end
            M_HEX1, M_HEX2: begin
                if (!hd[4]) begin
                    d_fail = 1'b1;
                end else if (r_hcnt != 2'd3) begin
                    n_hex  = v16;
                    n_hcnt = r_hcnt + 2'd1;
                end else begin
                    n_hex  = 16'd0;
                    n_hcnt = 2'd0;
                    if (r_mode == M_HEX1) begin
                        if (v16 >= SUR_HI_MIN && v16 <= SUR_HI_MAX) begin
                            n_hsur = v16[9:0];
                            n_mode = M_SUR_BS;
                        end else if (v16 >= SUR_LO_MIN && v16 <= SUR_LO_MAX) begin
                            d_fail = 1'b1;
                        end else begin
                            d_emit = 1'b1;
                            d_cp   = {5'd0, v16};
                        end
                    end else begin
                        if (v16 < SUR_LO_MIN || v16 > SUR_LO_MAX) begin
                            d_fail = 1'b1;
                        end else begin
                            d_emit = 1'b1;
                            d_cp   = CP_SUPP + {1'b0, r_hsur, v16[9:0]};
                            n_hsur = 10'd0;
                        end
                    end
                end
            end
            M_SUR_BS: begin
                if (r_in_byte == CH_BSLASH) begin
                    n_mode = M_SUR_U;
                end else begin
                    d_fail = 1'b1;
                end
            end
            M_SUR_U: begin
                if (r_in_byte == CH_U) begin
                    n_mode = M_HEX2;
                    n_hex  = 16'd0;
                    n_hcnt = 2'd0;
                end else begin
                    d_fail = 1'b1;
                end
            end
            default: d_fail = 1'b1;
        endcase

        // UTF-8 encode of a decoded code point
        if (d_emit) begin
            n_mode = M_STR;
            if (d_cp < 21'h80) begin
                d_num  = 3'd1;
                d_b[0] = d_cp[7:0];
            end else if (d_cp < 21'h800) begin
                d_num  = 3'd2;
                d_b[0] = {3'b110, d_cp[10:6]};
                d_b[1] = {2'b10, d_cp[5:0]};
            end else if (d_cp < CP_SUPP) begin
                d_num  = 3'd3;
                d_b[0] = {4'b1110, d_cp[15:12]};
                d_b[1] = {2'b10, d_cp[11:6]};
                d_b[2] = {2'b10, d_cp[5:0]};
            end else begin
                d_num  = 3'd4;
                d_b[0] = {5'b11110, d_cp[20:18]};
                d_b[1] = {2'b10, d_cp[17:12]};
                d_b[2] = {2'b10, d_cp[11:6]};
                d_b[3] = {2'b10, d_cp[5:0]};
            end
        end

        // Any error clears the escape state and returns to idle
        if (d_fail) begin
            n_mode = M_IDLE;
            n_hex  = 16'd0;
            n_hcnt = 2'd0;
            n_hsur = 10'd0;
            d_num  = 3'd1;
            d_st   = ST_ERR;
            for (int k = 0; k < 4; k++) begin
                d_b[k] = 8'd0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_ovld   <= 1'b0;
            r_pos    <= 2'd0;
            r_mode   <= M_IDLE;
            r_hex    <= 16'd0;
            r_hcnt   <= 2'd0;
            r_hsur   <= 10'd0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end

            // drain one result per transfer
            if (take) begin
                if (r_pos == r_num) begin
                    r_ovld <= 1'b0;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end

            if (proc) begin
                r_mode <= n_mode;
                r_hex  <= n_hex;
                r_hcnt <= n_hcnt;
                r_hsur <= n_hsur;
                if (d_num != 3'd0) begin
                    r_ovld <= 1'b1;
                    r_pos  <= 2'd0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
        end
        if (proc && (d_num != 3'd0)) begin
            r_buf <= d_b;
            r_bst <= d_st;
            r_num <= 2'(d_num - 3'd1);
        end
    end

`ifndef ASSERT_OFF
    // End and error results are always single
    a_single_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_bst != ST_DATA)) |-> (r_num == 2'd0))
        else $error("end or error status with more than one result");

    // Read pointer stays within the loaded results
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_pos <= r_num))
        else $error("result pointer beyond loaded count");

    // An error always leaves the parser idle
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && d_fail) |=> (r_mode == M_IDLE))
        else $error("parser not idle after error");

    // Partial hex digits exist only inside a \u escape
    a_hex_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt != 2'd0) |-> ((r_mode == M_HEX1) || (r_mode == M_HEX2)))
        else $error("hex digit count outside hex mode");
`endif

endmodule
